[rtl/lsa_pkg.sv]
// Shared types, widths and constants of the latency statistics accumulator.
`default_nettype none
package lsa_pkg;

	localparam int LATENCY_BITS = 32;
	localparam int COUNT_BITS   = 32;

	localparam int TIME_BITS    = 63;
	localparam int SUM_BITS     = 64;
	localparam int MUL_BITS     = 32;
	localparam int PROD_BITS    = 2 * MUL_BITS;
	localparam int DQ_BITS      = 2 * SUM_BITS;
	localparam int ROOT_BITS    = SUM_BITS / 2;
	// root remainder stays below 2*root, plus two shifted-in bits
	localparam int CSU_BITS     = ROOT_BITS + 3;
	localparam int STEP_BITS    = $clog2(DQ_BITS);

	localparam int MEAN_BITS    = 32;
	localparam int STD_BITS     = 32;
	localparam int EXT_BITS     = 31;
	localparam int CNT_OUT_BITS = 32;

	localparam logic [STEP_BITS-1:0] DIV64_LAST  = STEP_BITS'(SUM_BITS - 1);
	localparam logic [STEP_BITS-1:0] DIV128_LAST = STEP_BITS'(DQ_BITS - 1);
	localparam logic [STEP_BITS-1:0] SQRT_LAST   = STEP_BITS'(ROOT_BITS - 1);
	localparam logic [STEP_BITS-1:0] MUL_LO      = STEP_BITS'(1);
	localparam logic [STEP_BITS-1:0] MUL_MID     = STEP_BITS'(2);
	localparam logic [STEP_BITS-1:0] MUL_LAST    = STEP_BITS'(3);

	localparam logic [SUM_BITS-1:0] MEAN_POS_LIM = (SUM_BITS'(1) << (MEAN_BITS - 1)) - 1'b1;
	localparam logic [SUM_BITS-1:0] MEAN_NEG_LIM = SUM_BITS'(1) << (MEAN_BITS - 1);

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_REPORT = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_ABS,
		ST_DIV_M,
		ST_MEAN,
		ST_MUL,
		ST_DIV_T,
		ST_SUB,
		ST_DIV_V,
		ST_ROOT_LD,
		ST_SQRT,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic                ge;
		logic [CSU_BITS-1:0] diff;
	} csu_res_t;

endpackage
`default_nettype wire

[rtl/lsa_if.sv]
// Request and result channel interfaces of the latency statistics accumulator.
`default_nettype none
interface lsa_in_if;
	logic                           valid;
	logic                           ready;
	lsa_pkg::op_t                   op;
	logic [lsa_pkg::TIME_BITS-1:0]  end_time;
	logic [lsa_pkg::TIME_BITS-1:0]  start_time;

	modport source (output valid, output op, output end_time, output start_time, input ready);
	modport sink (input valid, input op, input end_time, input start_time, output ready);
endinterface

interface lsa_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [lsa_pkg::MEAN_BITS-1:0] mean_latency;
	logic [lsa_pkg::STD_BITS-1:0]        std_latency;
	logic [lsa_pkg::EXT_BITS-1:0]        min_latency;
	logic [lsa_pkg::EXT_BITS-1:0]        max_latency;
	logic [lsa_pkg::CNT_OUT_BITS-1:0]    valid_samples;
	logic [lsa_pkg::CNT_OUT_BITS-1:0]    total_samples;

	modport source (output valid, output mean_latency, output std_latency, output min_latency,
		output max_latency, output valid_samples, output total_samples, input ready);
	modport sink (input valid, input mean_latency, input std_latency, input min_latency,
		input max_latency, input valid_samples, input total_samples, output ready);
endinterface
`default_nettype wire

[rtl/lsa_csu.sv]
// Shared compare-subtract unit for the divide and square-root steps.
`default_nettype none
module lsa_csu (
	input  logic [lsa_pkg::CSU_BITS-1:0] cand,
	input  logic [lsa_pkg::CSU_BITS-1:0] operand,
	output lsa_pkg::csu_res_t            res
);
	import lsa_pkg::*;

	logic [CSU_BITS:0] wide;

	assign wide     = {1'b0, cand} - {1'b0, operand};
	assign res.ge   = ~wide[CSU_BITS];
	assign res.diff = wide[CSU_BITS-1:0];
endmodule
`default_nettype wire

[rtl/lsa_mul.sv]
// Registered 32x32 unsigned multiplier shared by the sample and report paths.
`default_nettype none
module lsa_mul (
	input  logic                          clk,
	input  logic [lsa_pkg::MUL_BITS-1:0]  a,
	input  logic [lsa_pkg::MUL_BITS-1:0]  b,
	output logic [lsa_pkg::PROD_BITS-1:0] prod_q
);
	import lsa_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(a) * PROD_BITS'(b);
	end
endmodule
`default_nettype wire

[rtl/latency_statistics_accumulator.sv]
// Latency statistics accumulator top level: sequencer, statistics registers, result register.
//
// Requests enter on sample_in (valid/ready, accepted when both are high). A sample
// request carries two timestamps; when both are nonzero their saturated difference
// updates count, sum, sum of squares, minimum and maximum, and the total count
// advances either way. A report request returns one result on stats_out with the
// truncated mean, the integer standard deviation, minimum, maximum and both counts.
// A sample request passes through the difference, square and accumulate states,
// or only the difference state when a stamp is absent. A report request runs
// 64 + 128 + 64 divide steps and 32 root steps, each one pass through the shared
// compare-subtract unit, plus the squared sum on the shared multiplier. With no valid
// samples the sequencer goes from the absolute-value state straight to its final state.
// ready is high only while the sequencer is idle. The result sits in an output
// register, so the next request is taken while it waits; a stalled receiver holds
// a second report in its final state until the register frees.
// Reset clears all counts and sums, sets the minimum to unset and the maximum to 0.
`default_nettype none
module latency_statistics_accumulator (
	input  logic      clk,
	input  logic      arst_n,
	lsa_in_if.sink    sample_in,
	lsa_out_if.source stats_out
);
	import lsa_pkg::*;

	localparam logic signed [LATENCY_BITS-1:0] LAT_MAX = {1'b0, {(LATENCY_BITS-1){1'b1}}};
	localparam logic signed [LATENCY_BITS-1:0] LAT_MIN = {1'b1, {(LATENCY_BITS-1){1'b0}}};

	st_t state_q, state_d;

	logic [TIME_BITS-1:0]           end_q, start_q;
	logic signed [LATENCY_BITS-1:0] d_q;
	logic [COUNT_BITS-1:0]          valid_cnt_q, total_cnt_q;
	logic [SUM_BITS-1:0]            sum_q, sq_sum_q;
	logic signed [LATENCY_BITS-1:0] least_q, greatest_q;
	logic                           neg_q;
	logic [SUM_BITS-1:0]            m_q;
	logic [DQ_BITS-1:0]             dq_q;
	logic [CSU_BITS-1:0]            rem_q;
	logic [ROOT_BITS-1:0]           root_q;
	logic [STEP_BITS-1:0]           step_q;
	logic signed [MEAN_BITS-1:0]    mean_q;
	logic                           out_valid_q;

	logic signed [MEAN_BITS-1:0]    res_mean_q;
	logic [STD_BITS-1:0]            res_std_q;
	logic [EXT_BITS-1:0]            res_min_q, res_max_q;
	logic [CNT_OUT_BITS-1:0]        res_valid_q, res_total_q;

	logic                           in_acc, out_free, stamps_ok, d_fits;
	logic signed [SUM_BITS-1:0]     raw_diff;
	logic signed [LATENCY_BITS-1:0] d_sat;
	logic [LATENCY_BITS-1:0]        mag;
	logic [MUL_BITS-1:0]            mul_a, mul_b;
	logic [PROD_BITS-1:0]           prod;
	logic [SUM_BITS-1:0]            abs_sum, qm, t_val;
	logic signed [MEAN_BITS-1:0]    mean_sat;
	logic [CSU_BITS-1:0]            div_cand, sq_cand, csu_cand, csu_op;
	csu_res_t                       csu;

	assign in_acc          = sample_in.valid && sample_in.ready;
	assign sample_in.ready = (state_q == ST_IDLE);
	assign out_free        = !out_valid_q || stats_out.ready;
	assign stamps_ok       = (|end_q) && (|start_q);

	// difference, saturated to the latency range
	assign raw_diff = $signed({1'b0, end_q}) - $signed({1'b0, start_q});
	assign d_fits   = (&raw_diff[SUM_BITS-1:LATENCY_BITS-1]) ||
	                  !(|raw_diff[SUM_BITS-1:LATENCY_BITS-1]);
	assign d_sat    = d_fits ? raw_diff[LATENCY_BITS-1:0] :
	                  (raw_diff[SUM_BITS-1] ? LAT_MIN : LAT_MAX);
	assign mag      = d_q[LATENCY_BITS-1] ? (~d_q + 1'b1) : d_q;

	assign abs_sum  = sum_q[SUM_BITS-1] ? (~sum_q + 1'b1) : sum_q;
	assign qm       = dq_q[SUM_BITS-1:0];
	assign t_val    = dq_q[SUM_BITS-1:0];

	always_comb begin
		if (neg_q) begin
			mean_sat = (qm > MEAN_NEG_LIM) ? MEAN_BITS'(MEAN_NEG_LIM)
			                               : MEAN_BITS'(SUM_BITS'(0) - qm);
		end else begin
			mean_sat = (qm > MEAN_POS_LIM) ? MEAN_BITS'(MEAN_POS_LIM) : MEAN_BITS'(qm);
		end
	end

	always_comb begin
		mul_a = MUL_BITS'(mag);
		mul_b = MUL_BITS'(mag);
		if (state_q == ST_MUL) begin
			case (step_q)
				'0: begin
					mul_a = m_q[MUL_BITS-1:0];
					mul_b = m_q[MUL_BITS-1:0];
				end
				MUL_LO: begin
					mul_a = m_q[SUM_BITS-1:MUL_BITS];
					mul_b = m_q[MUL_BITS-1:0];
				end
				default: begin
					mul_a = m_q[SUM_BITS-1:MUL_BITS];
					mul_b = m_q[SUM_BITS-1:MUL_BITS];
				end
			endcase
		end
	end

	lsa_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign div_cand = {rem_q[CSU_BITS-2:0], dq_q[DQ_BITS-1]};
	assign sq_cand  = {rem_q[CSU_BITS-3:0], dq_q[DQ_BITS-1 -: 2]};
	assign csu_cand = (state_q == ST_SQRT) ? sq_cand : div_cand;
	assign csu_op   = (state_q == ST_SQRT) ? CSU_BITS'({root_q, 2'b01})
	                                       : CSU_BITS'(valid_cnt_q);

	lsa_csu u_csu (
		.cand    (csu_cand),
		.operand (csu_op),
		.res     (csu)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (sample_in.op == OP_REPORT) ? ST_ABS : ST_DIFF;
				end
			end
			ST_DIFF:    state_d = stamps_ok ? ST_SQ_MUL : ST_IDLE;
			ST_SQ_MUL:  state_d = ST_SQ_ACC;
			ST_SQ_ACC:  state_d = ST_IDLE;
			ST_ABS:     state_d = (valid_cnt_q == '0) ? ST_FIN : ST_DIV_M;
			ST_DIV_M: begin
				if (step_q == DIV64_LAST) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN:    state_d = ST_MUL;
			ST_MUL: begin
				if (step_q == MUL_LAST) begin
					state_d = ST_DIV_T;
				end
			end
			ST_DIV_T: begin
				if (step_q == DIV128_LAST) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				if ((|dq_q[DQ_BITS-1:SUM_BITS]) || (t_val > sq_sum_q)) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_DIV_V;
				end
			end
			ST_DIV_V: begin
				if (step_q == DIV64_LAST) begin
					state_d = ST_ROOT_LD;
				end
			end
			ST_ROOT_LD: state_d = ST_SQRT;
			ST_SQRT: begin
				if (step_q == SQRT_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			valid_cnt_q <= '0;
			total_cnt_q <= '0;
			sum_q       <= '0;
			sq_sum_q    <= '0;
			least_q     <= '1;
			greatest_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (stats_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_DIFF: begin
					if (total_cnt_q != '1) begin
						total_cnt_q <= total_cnt_q + 1'b1;
					end
				end
				ST_SQ_ACC: begin
					if (valid_cnt_q != '1) begin
						valid_cnt_q <= valid_cnt_q + 1'b1;
					end
					sum_q    <= sum_q + SUM_BITS'(d_q);
					sq_sum_q <= sq_sum_q + prod;
					if (least_q[LATENCY_BITS-1] || (d_q < least_q)) begin
						least_q <= d_q;
					end
					if (d_q > greatest_q) begin
						greatest_q <= d_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					end_q   <= sample_in.end_time;
					start_q <= sample_in.start_time;
				end
			end
			ST_DIFF: d_q <= d_sat;
			ST_ABS: begin
				neg_q  <= sum_q[SUM_BITS-1];
				m_q    <= abs_sum;
				dq_q   <= {abs_sum, SUM_BITS'(0)};
				rem_q  <= '0;
				mean_q <= '0;
				root_q <= '0;
			end
			ST_DIV_M, ST_DIV_T, ST_DIV_V: begin
				rem_q <= csu.ge ? csu.diff : csu_cand;
				dq_q  <= {dq_q[DQ_BITS-2:0], csu.ge};
			end
			ST_MEAN: mean_q <= mean_sat;
			ST_MUL: begin
				case (step_q)
					MUL_LO:   dq_q <= DQ_BITS'(prod);
					MUL_MID:  dq_q <= dq_q + (DQ_BITS'(prod) << (MUL_BITS + 1));
					MUL_LAST: begin
						dq_q  <= dq_q + (DQ_BITS'(prod) << SUM_BITS);
						rem_q <= '0;
					end
					default: ;
				endcase
			end
			ST_SUB: begin
				dq_q  <= {sq_sum_q - t_val, SUM_BITS'(0)};
				rem_q <= '0;
			end
			ST_ROOT_LD: begin
				dq_q   <= {dq_q[SUM_BITS-1:0], SUM_BITS'(0)};
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= csu.ge ? csu.diff : csu_cand;
				root_q <= {root_q[ROOT_BITS-2:0], csu.ge};
				dq_q   <= {dq_q[DQ_BITS-3:0], 2'b00};
			end
			ST_FIN: begin
				if (out_free) begin
					res_mean_q  <= mean_q;
					res_std_q   <= STD_BITS'(root_q);
					res_min_q   <= least_q[LATENCY_BITS-1] ? '0
					                                       : EXT_BITS'(least_q[LATENCY_BITS-2:0]);
					res_max_q   <= EXT_BITS'(greatest_q[LATENCY_BITS-2:0]);
					res_valid_q <= CNT_OUT_BITS'(valid_cnt_q);
					res_total_q <= CNT_OUT_BITS'(total_cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign stats_out.valid         = out_valid_q;
	assign stats_out.mean_latency  = res_mean_q;
	assign stats_out.std_latency   = res_std_q;
	assign stats_out.min_latency   = res_min_q;
	assign stats_out.max_latency   = res_max_q;
	assign stats_out.valid_samples = res_valid_q;
	assign stats_out.total_samples = res_total_q;

	a_valid_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		valid_cnt_q <= total_cnt_q)
		else $error("valid count exceeds total count");

	a_rem_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_M || state_q == ST_DIV_T || state_q == ST_DIV_V) |->
		(rem_q < CSU_BITS'(valid_cnt_q)))
		else $error("divide remainder not below sample count");

	a_sq_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SQ_ACC) |=> $stable(sq_sum_q))
		else $error("sum of squares changed outside accumulate step");

	a_max_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!greatest_q[LATENCY_BITS-1])
		else $error("maximum went negative");

endmodule
`default_nettype wire
